@@ src/lspg_pkg.sv @@
package lspg_pkg;

	// Default strip length and the width of the LED index field.
	localparam int LSPG_NUM_LEDS = 16;
	localparam int LED_INDEX_W   = 4;
	localparam int CHAN_W        = 8;

	// Frame parameter handed from the front to the back: the hue origin
	// for the rainbow, or the breathing gain in the low byte.
	localparam int PARAM_W = 16;

	// Divider geometry: the time is extended by a 16-bit fraction, and the
	// divisor is at most 255 * 100 ms, which fits in 15 bits.
	localparam int TIME_W      = 32;
	localparam int DIVIDEND_W  = TIME_W + PARAM_W;
	localparam int DIVISOR_W   = 15;
	localparam int DIV_CYCLES  = DIVIDEND_W / 2;
	localparam int DIV_CNT_W   = 5;

	// Breathing cycle length in ms and the length of one period unit in ms.
	localparam logic [DIVISOR_W-1:0] BREATH_PERIOD_MS = 15'd4000;
	localparam logic [DIVISOR_W-1:0] PERIOD_UNIT_MS   = 15'd100;

	// Breathing gain numerator: 147200 + 425 * sine, then divided by 256000.
	// The division is a shift by 11 and a reciprocal multiply for 125.
	localparam logic signed [19:0] BREATH_BIAS  = 20'sd147200;
	localparam logic signed [19:0] BREATH_SLOPE = 20'sd425;
	localparam logic [15:0]        RECIP_125    = 16'd33555;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_MODE            = 2'd0,
		REG_BASE_COLOR      = 2'd1,
		REG_BRIGHTNESS      = 2'd2,
		REG_GRADIENT_PERIOD = 2'd3
	} reg_index_t;

	// Animation modes.
	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_SOLID   = 2'd1,
		MODE_BREATH  = 2'd2,
		MODE_RAINBOW = 2'd3
	} mode_t;

	// Configuration as seen by the front and the back.
	typedef struct packed {
		mode_t       mode;
		logic [23:0] base_color;
		logic [7:0]  brightness;
		logic [7:0]  gradient_period;
	} cfg_t;

	// Quarter wave of the Q8 sine, entries 0..64.
	localparam logic [8:0] SIN_QUARTER [0:64] = '{
		9'd0,   9'd6,   9'd13,  9'd19,  9'd25,  9'd31,  9'd38,  9'd44,
		9'd50,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
		9'd98,  9'd104, 9'd109, 9'd115, 9'd121, 9'd126, 9'd132, 9'd137,
		9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd172, 9'd177,
		9'd181, 9'd185, 9'd190, 9'd194, 9'd198, 9'd202, 9'd206, 9'd209,
		9'd213, 9'd216, 9'd220, 9'd223, 9'd226, 9'd229, 9'd231, 9'd234,
		9'd237, 9'd239, 9'd241, 9'd243, 9'd245, 9'd247, 9'd248, 9'd250,
		9'd251, 9'd252, 9'd253, 9'd254, 9'd255, 9'd255, 9'd256, 9'd256,
		9'd256
	};

	// Full 256-entry sine through quarter-wave symmetry.
	function automatic logic signed [9:0] sine_q8(input logic [7:0] k);
		logic [6:0] j;
		logic [8:0] mag;
		j = {1'b0, k[5:0]};
		case (k[7:6])
			2'd0:    mag = SIN_QUARTER[j];
			2'd1:    mag = SIN_QUARTER[7'd64 - j];
			2'd2:    mag = SIN_QUARTER[j];
			default: mag = SIN_QUARTER[7'd64 - j];
		endcase
		if (k[7]) begin
			sine_q8 = -$signed({1'b0, mag});
		end else begin
			sine_q8 = $signed({1'b0, mag});
		end
	endfunction

	// floor(p / 255) for any product of two 8-bit values.
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] sum;
		sum = 17'(p) + 17'd1 + 17'(p[15:8]);
		div255 = sum[15:8];
	endfunction

endpackage

@@ src/led_strip_pattern_generator_core.sv @@
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: time_ms[31:0]
// m_*       out  m_tvalid/m_tready  m_tdata: led_index, red, green, blue; m_tlast: last
// cfg_*     in   cfg_we             cfg_index selects the register, cfg_data the value
//
// Each frame tick yields NUM_LEDS colour transfers, one per cycle while m_tready is high.
// The front runs a tick through the 2-bit-per-cycle phase divider and the breathing gain
// steps; the back emits one LED per cycle, when not stalled, through stages s1 to s4 and
// an output register. A tick is held in an input register while the previous one works.
// Reset clears the handshake state; gradient_period resets to 10, other registers to 0.
// A stall on m_tready freezes the back pipeline; the front keeps running into a
// two-entry frame queue.
module led_strip_pattern_generator_core
	import lspg_pkg::*;
#(
	parameter int NUM_LEDS = LSPG_NUM_LEDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] time_ms
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [3:0] led_index, [11:4] red, [19:12] green,
	                               // [27:20] blue, [31:28] zero
	output logic        m_tlast
);

	cfg_t                   cfg_q;
	logic                   push_valid;
	logic [PARAM_W-1:0]     push_param;
	logic                   push_ready;
	logic                   frame_valid;
	logic [PARAM_W-1:0]     frame_param;
	logic                   frame_pop;
	logic [LED_INDEX_W-1:0] led_index;
	logic [CHAN_W-1:0]      red, green, blue;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= MODE_OFF;
			cfg_q.base_color      <= 24'd0;
			cfg_q.brightness      <= 8'd0;
			cfg_q.gradient_period <= 8'd10;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MODE:            cfg_q.mode            <= mode_t'(cfg_data[1:0]);
				REG_BASE_COLOR:      cfg_q.base_color      <= cfg_data;
				REG_BRIGHTNESS:      cfg_q.brightness      <= cfg_data[7:0];
				REG_GRADIENT_PERIOD: cfg_q.gradient_period <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lspg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_time    (s_tdata),
		.push_valid (push_valid),
		.push_param (push_param),
		.push_ready (push_ready)
	);

	lspg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_data  (push_param),
		.wr_ready (push_ready),
		.rd_valid (frame_valid),
		.rd_data  (frame_param),
		.rd_pop   (frame_pop)
	);

	lspg_back #(
		.NUM_LEDS (NUM_LEDS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.frame_valid (frame_valid),
		.frame_param (frame_param),
		.frame_pop   (frame_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.led_index   (led_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last        (m_tlast)
	);

	// Pack the result fields, lowest field first.
	assign m_tdata = {4'd0, blue, green, red, led_index};

endmodule

@@ src/lspg_queue.sv @@
module lspg_queue
	import lspg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	input  logic [PARAM_W-1:0] wr_data,
	output logic               wr_ready,
	output logic               rd_valid,
	output logic [PARAM_W-1:0] rd_data,
	input  logic               rd_pop
);

	logic [PARAM_W-1:0] entry_q [0:1];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               push;
	logic               pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ src/lspg_front.sv @@
module lspg_front
	import lspg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TIME_W-1:0]  in_time,
	output logic               push_valid,
	output logic [PARAM_W-1:0] push_param,
	input  logic               push_ready
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_DIV,
		F_SINE,
		F_MUL,
		F_RECIP,
		F_PUSH
	} front_state_t;

	front_state_t           state_q;
	logic                   hold_valid_q;
	logic [TIME_W-1:0]      hold_time_q;
	logic [DIVIDEND_W-1:0]  num_q;
	logic [DIVISOR_W-1:0]   rem_q;
	logic [DIVISOR_W-1:0]   div_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [17:0]            gnum_q;
	logic [25:0]            gprod_q;
	logic [PARAM_W-1:0]     param_q;

	logic                   take;
	logic [7:0]             period_eff;
	logic [DIVISOR_W-1:0]   div_next;

	// Two restoring division steps per cycle.
	logic [DIVISOR_W:0]     trial_a;
	logic [DIVISOR_W-1:0]   rem_a;
	logic                   qbit_a;
	logic [DIVISOR_W:0]     trial_b;
	logic [DIVISOR_W-1:0]   rem_b;
	logic                   qbit_b;
	logic [DIVIDEND_W-1:0]  num_next;

	logic signed [9:0]      sine;
	logic signed [19:0]     gnum_full;
	logic [30:0]            recip_prod;

	assign in_ready   = !hold_valid_q;
	assign take       = (state_q == F_IDLE) && hold_valid_q;
	assign push_valid = (state_q == F_PUSH);
	assign push_param = param_q;

	// Divisor: the breathing cycle, or the clamped rainbow period in ms.
	always_comb begin
		period_eff = (cfg.gradient_period == 8'd0) ? 8'd1 : cfg.gradient_period;
		if (cfg.mode == MODE_BREATH) begin
			div_next = BREATH_PERIOD_MS;
		end else begin
			div_next = DIVISOR_W'(period_eff) * PERIOD_UNIT_MS;
		end
	end

	// The quotient of time * 2^16 by the divisor has, in its low 16 bits,
	// the phase fraction within the current cycle.
	always_comb begin
		trial_a  = {rem_q, num_q[DIVIDEND_W-1]};
		qbit_a   = (trial_a >= {1'b0, div_q});
		rem_a    = qbit_a ? DIVISOR_W'(trial_a - {1'b0, div_q}) : DIVISOR_W'(trial_a);
		trial_b  = {rem_a, num_q[DIVIDEND_W-2]};
		qbit_b   = (trial_b >= {1'b0, div_q});
		rem_b    = qbit_b ? DIVISOR_W'(trial_b - {1'b0, div_q}) : DIVISOR_W'(trial_b);
		num_next = {num_q[DIVIDEND_W-3:0], qbit_a, qbit_b};
	end

	// Breathing gain numerator from the sine of the phase.
	always_comb begin
		sine       = sine_q8(num_q[15:8]);
		gnum_full  = BREATH_BIAS + BREATH_SLOPE * 20'(sine);
		recip_prod = 31'(gprod_q[25:11]) * 31'(RECIP_125);
	end

	// Input holding register: a new tick is taken while the last one works.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			hold_valid_q <= 1'b1;
		end else if (take) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hold_time_q <= in_time;
		end
	end

	// Sequencer: divide for breathing and rainbow, then for breathing work the gain out in three steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take) begin
						cnt_q <= '0;
						if (cfg.mode == MODE_BREATH || cfg.mode == MODE_RAINBOW) begin
							state_q <= F_DIV;
						end else begin
							state_q <= F_PUSH;
						end
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
						if (cfg.mode == MODE_BREATH) begin
							state_q <= F_SINE;
						end else begin
							state_q <= F_PUSH;
						end
					end
				end
				F_SINE:  state_q <= F_MUL;
				F_MUL:   state_q <= F_RECIP;
				F_RECIP: state_q <= F_PUSH;
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				num_q   <= {hold_time_q, PARAM_W'(0)};
				rem_q   <= '0;
				div_q   <= div_next;
				param_q <= '0;
			end
			F_DIV: begin
				num_q   <= num_next;
				rem_q   <= rem_b;
				param_q <= num_next[PARAM_W-1:0];
			end
			F_SINE:  gnum_q  <= gnum_full[17:0];
			F_MUL:   gprod_q <= 26'(cfg.brightness) * 26'(gnum_q);
			F_RECIP: param_q <= PARAM_W'(recip_prod[29:22]);
			default: ;
		endcase
	end

endmodule

@@ src/lspg_back.sv @@
module lspg_back
	import lspg_pkg::*;
#(
	parameter int NUM_LEDS = LSPG_NUM_LEDS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   frame_valid,
	input  logic [PARAM_W-1:0]     frame_param,
	output logic                   frame_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [LED_INDEX_W-1:0] led_index,
	output logic [CHAN_W-1:0]      red,
	output logic [CHAN_W-1:0]      green,
	output logic [CHAN_W-1:0]      blue,
	output logic                   last
);

	localparam int IDX_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int EXT_W    = (IDX_W > LED_INDEX_W) ? IDX_W : LED_INDEX_W;
	localparam int FRAC_W   = IDX_W + 1;
	localparam int OFF_STEP = 65536 / NUM_LEDS;
	localparam int OFF_REM  = 65536 % NUM_LEDS;

	logic                  adv;
	logic                  issue;
	logic                  at_last;

	// LED sequencer with an exact running offset of i * 65536 / NUM_LEDS.
	logic [IDX_W-1:0]      idx_q;
	logic [PARAM_W-1:0]    off_q;
	logic [FRAC_W-1:0]     frac_q;
	logic [FRAC_W-1:0]     frac_sum;
	logic                  frac_wrap;

	logic                  valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic [IDX_W-1:0]      idx_s1, idx_s2, idx_s3, idx_s4;
	logic                  last_s1, last_s2, last_s3, last_s4;
	logic [PARAM_W-1:0]    param_s1;
	logic [PARAM_W-1:0]    off_s1;
	logic [7:0]            gain_s2;
	logic [2:0]            sector_s2;
	logic [15:0]           frac_s2;
	logic [CHAN_W-1:0]     cr_s3, cg_s3, cb_s3, gain_s3;
	logic [15:0]           pr_s4, pg_s4, pb_s4;
	logic [EXT_W-1:0]      idx_out_q;
	logic                  last_q;
	logic [CHAN_W-1:0]     red_q, green_q, blue_q;

	logic [PARAM_W-1:0]    hue;
	logic [18:0]           hue6;
	logic [23:0]           up_full;
	logic [16:0]           inv_frac;
	logic [24:0]           down_full;
	logic [7:0]            up, down;
	logic [7:0]            hr, hg, hb;
	logic [7:0]            sel_r, sel_g, sel_b, sel_gain;

	assign adv       = !out_valid_q || out_ready;
	assign issue     = frame_valid && adv;
	assign at_last   = (idx_q == IDX_W'(NUM_LEDS - 1));
	assign frame_pop = issue && at_last;

	assign frac_sum  = frac_q + FRAC_W'(OFF_REM);
	assign frac_wrap = (frac_sum >= FRAC_W'(NUM_LEDS));

	// Step through the LEDs of the frame at the head of the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			off_q  <= '0;
			frac_q <= '0;
		end else if (issue) begin
			if (at_last) begin
				idx_q  <= '0;
				off_q  <= '0;
				frac_q <= '0;
			end else begin
				idx_q  <= idx_q + IDX_W'(1);
				off_q  <= off_q + PARAM_W'(OFF_STEP) + PARAM_W'(frac_wrap);
				frac_q <= frac_wrap ? FRAC_W'(frac_sum - FRAC_W'(NUM_LEDS)) : frac_sum;
			end
		end
	end

	// Hue position and sextant.
	always_comb begin
		hue  = param_s1 + off_s1;
		hue6 = (19'(hue) << 2) + (19'(hue) << 1);
	end

	// Ramp values within the sextant and the colour and gain for the mode.
	always_comb begin
		up_full   = {frac_s2, 8'd0} - 24'(frac_s2);
		inv_frac  = 17'h10000 - 17'(frac_s2);
		down_full = {inv_frac, 8'd0} - 25'(inv_frac);
		up        = up_full[23:16];
		down      = down_full[23:16];
		case (sector_s2)
			3'd0:    begin hr = 8'd255; hg = up;     hb = 8'd0;   end
			3'd1:    begin hr = down;   hg = 8'd255; hb = 8'd0;   end
			3'd2:    begin hr = 8'd0;   hg = 8'd255; hb = up;     end
			3'd3:    begin hr = 8'd0;   hg = down;   hb = 8'd255; end
			3'd4:    begin hr = up;     hg = 8'd0;   hb = 8'd255; end
			default: begin hr = 8'd255; hg = 8'd0;   hb = down;   end
		endcase
		case (cfg.mode)
			MODE_SOLID: begin
				sel_r    = cfg.base_color[23:16];
				sel_g    = cfg.base_color[15:8];
				sel_b    = cfg.base_color[7:0];
				sel_gain = cfg.brightness;
			end
			MODE_BREATH: begin
				sel_r    = cfg.base_color[23:16];
				sel_g    = cfg.base_color[15:8];
				sel_b    = cfg.base_color[7:0];
				sel_gain = gain_s2;
			end
			MODE_RAINBOW: begin
				sel_r    = hr;
				sel_g    = hg;
				sel_b    = hb;
				sel_gain = cfg.brightness;
			end
			default: begin
				sel_r    = 8'd0;
				sel_g    = 8'd0;
				sel_b    = 8'd0;
				sel_gain = 8'd0;
			end
		endcase
	end

	// Valid bits of the pipeline; the whole pipeline moves when the output
	// register is free or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= issue;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1    <= idx_q;
			last_s1   <= at_last;
			param_s1  <= frame_param;
			off_s1    <= off_q;

			idx_s2    <= idx_s1;
			last_s2   <= last_s1;
			gain_s2   <= param_s1[7:0];
			sector_s2 <= hue6[18:16];
			frac_s2   <= hue6[15:0];

			idx_s3    <= idx_s2;
			last_s3   <= last_s2;
			cr_s3     <= sel_r;
			cg_s3     <= sel_g;
			cb_s3     <= sel_b;
			gain_s3   <= sel_gain;

			idx_s4    <= idx_s3;
			last_s4   <= last_s3;
			pr_s4     <= 16'(cr_s3) * 16'(gain_s3);
			pg_s4     <= 16'(cg_s3) * 16'(gain_s3);
			pb_s4     <= 16'(cb_s3) * 16'(gain_s3);

			idx_out_q <= EXT_W'(idx_s4);
			last_q    <= last_s4;
			red_q     <= div255(pr_s4);
			green_q   <= div255(pg_s4);
			blue_q    <= div255(pb_s4);
		end
	end

	assign out_valid = out_valid_q;
	assign led_index = idx_out_q[LED_INDEX_W-1:0];
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign last      = last_q;

endmodule
